// ===== rtl/tps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tps_pkg
// Types, constants and helper functions shared by the tiered poll scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 40;
  localparam int CODE_W    = 8;
  localparam int NUM_CODES = 256;
  localparam int RTT_W     = 16;
  localparam int IVL_W     = 17;
  localparam int MULT_W    = 5;
  localparam int PERIOD_W  = IVL_W + MULT_W;

  localparam logic [7:0]       STREAM_MODE   = 8'h01;
  localparam logic [RTT_W-1:0] TIMEOUT_FLOOR = 16'd1000;
  localparam logic [IVL_W-1:0] INTERVAL_MIN  = 17'd10;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_ADD      = 3'd1,
    OP_ENQ      = 3'd2,
    OP_POLL     = 3'd3,
    OP_COMPLETE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    TIER_HIGH = 2'd0,
    TIER_MED  = 2'd1,
    TIER_LOW  = 2'd2
  } tier_t;

  typedef struct packed {
    logic load;
    logic clear_map;
    logic add_code;
    logic enqueue;
    logic dequeue;
    logic complete;
    logic scan_start;
    logic scan_run;
    logic sched_calc;
    logic sched_write;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic outstanding;
    logic queue_nonempty;
    logic scan_last;
    logic pipe_busy;
    logic found;
    logic out_free;
  } stat_t;

  function automatic tier_t tier_of(input logic [CODE_W-1:0] c);
    tier_t t;
    t = TIER_LOW;
    if (c == 8'h0C || c == 8'h0D || c == 8'h11) begin
      t = TIER_HIGH;
    end else if (c == 8'h04 || c == 8'h0B || c == 8'h0E || c == 8'h10 ||
                 (c >= 8'h14 && c <= 8'h2B)) begin
      t = TIER_MED;
    end
    return t;
  endfunction

  function automatic logic [MULT_W-1:0] period_mult(input tier_t t, input logic congested);
    logic [MULT_W-1:0] m;
    unique case (t)
      TIER_HIGH: m = 5'd3;
      TIER_MED:  m = congested ? 5'd10 : 5'd6;
      default:   m = congested ? 5'd20 : 5'd12;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tps_ctrl
// Sequencer: takes one beat, runs the operation on the datapath, hands the
// result to the output register.
// ----------------------------------------------------------------------------
module tps_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tps_pkg::stat_t stat,
  output tps_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FLUSH,
    S_PERIOD,
    S_SCHED,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_EMIT;
        unique case (stat.op)
          tps_pkg::OP_CLEAR:    cmd.clear_map = 1'b1;
          tps_pkg::OP_ADD:      cmd.add_code  = 1'b1;
          tps_pkg::OP_ENQ:      cmd.enqueue   = 1'b1;
          tps_pkg::OP_COMPLETE: cmd.complete  = 1'b1;
          tps_pkg::OP_POLL: begin
            if (!stat.outstanding) begin
              if (stat.queue_nonempty) begin
                cmd.dequeue = 1'b1;
              end else begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
              end
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pipe_busy) begin
          state_next = stat.found ? S_PERIOD : S_EMIT;
        end
      end
      S_PERIOD: begin
        cmd.sched_calc = 1'b1;
        state_next     = S_SCHED;
      end
      S_SCHED: begin
        cmd.sched_write = 1'b1;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tps_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tps_datapath
// Code map, due-time memory, diagnostic queue, round-trip filter, due scan
// pipeline and output register.
// ----------------------------------------------------------------------------
module tps_datapath #(
  parameter int DIAG_QUEUE_DEPTH = 8,
  parameter int TIME_BITS        = 48
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire tps_pkg::cmd_t                   cmd,
  output tps_pkg::stat_t                       stat,
  input  wire logic [tps_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic [2:0]                      s_tuser,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_data,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [tps_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic [0:0]                           m_tuser
);

  localparam int CNT_W = $clog2(DIAG_QUEUE_DEPTH + 1);
  localparam int PTR_W = (DIAG_QUEUE_DEPTH > 1) ? $clog2(DIAG_QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DIAG_QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DIAG_QUEUE_DEPTH);

  // latched item
  tps_pkg::op_t                  it_op;
  logic [7:0]                    it_code;
  logic [7:0]                    it_mode;
  logic [TIME_BITS-1:0]          it_now;
  logic [tps_pkg::RTT_W-1:0]     it_rtt;
  logic                          it_tmo;
  logic [TIME_BITS+47:0]         now_wide;

  logic congested;

  // code map and due times
  logic [tps_pkg::NUM_CODES-1:0] map_bits;
  logic [TIME_BITS-1:0]          due_mem [tps_pkg::NUM_CODES];
  logic                          mem_we;
  logic [7:0]                    mem_waddr;
  logic [TIME_BITS-1:0]          mem_wdata;

  // diagnostic queue
  logic [15:0]      fifo_mem [DIAG_QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             outstanding;

  logic [tps_pkg::RTT_W-1:0] srtt;
  logic [tps_pkg::RTT_W-1:0] obs;
  logic [18:0]               srtt_sum;
  logic [18:0]               srtt_x5;
  logic [tps_pkg::IVL_W-1:0] ivl_raw;
  logic [tps_pkg::IVL_W-1:0] interval;

  // scan pipeline
  logic [7:0]           scan_addr;
  logic                 rd_v;
  logic                 map_q;
  logic [7:0]           code_q;
  logic [TIME_BITS-1:0] mem_q;
  logic                 a_v;
  logic                 a_cand;
  tps_pkg::tier_t       a_tier;
  logic [7:0]           a_code;
  logic [TIME_BITS-1:0] a_due;
  logic                 best_found;
  tps_pkg::tier_t       best_tier;
  logic [7:0]           best_code;
  logic [TIME_BITS-1:0] best_due;
  logic                 better;

  logic [tps_pkg::PERIOD_W-1:0] period_q;
  logic [TIME_BITS:0]           due_sum;
  logic [TIME_BITS-1:0]         due_new;

  // result
  logic       res_valid;
  logic [7:0] res_mode;
  logic [7:0] res_code;
  logic       res_diag;
  logic       res_status;

  assign now_wide = {{TIME_BITS{1'b0}}, s_tdata[63:16]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_op   <= tps_pkg::op_t'(s_tuser);
      it_code <= s_tdata[7:0];
      it_mode <= s_tdata[15:8];
      it_now  <= now_wide[TIME_BITS-1:0];
      it_rtt  <= s_tdata[79:64];
      it_tmo  <= s_tdata[80];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      congested <= 1'b0;
    end else if (cfg_valid) begin
      congested <= cfg_data;
    end
  end

  // round-trip filter and dispatch interval
  assign obs      = (it_tmo && it_rtt < tps_pkg::TIMEOUT_FLOOR) ? tps_pkg::TIMEOUT_FLOOR : it_rtt;
  assign srtt_sum = {srtt, 3'b000} - {3'b000, srtt} + {3'b000, obs};
  assign srtt_x5  = {1'b0, srtt, 2'b00} + {3'b000, srtt};
  assign ivl_raw  = srtt_x5[18:2];
  assign interval = (ivl_raw < tps_pkg::INTERVAL_MIN) ? tps_pkg::INTERVAL_MIN : ivl_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      srtt <= '0;
    end else if (cmd.complete) begin
      srtt <= srtt_sum[18:3];
    end
  end

  // map and due memory
  assign due_sum = {1'b0, it_now} + (TIME_BITS + 1)'(period_q);
  assign due_new = due_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : due_sum[TIME_BITS-1:0];

  assign mem_we    = (cmd.add_code && !map_bits[it_code]) || cmd.sched_write;
  assign mem_waddr = cmd.sched_write ? best_code : it_code;
  assign mem_wdata = cmd.sched_write ? due_new : '0;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_map) begin
      map_bits <= '0;
    end else if (cmd.add_code) begin
      map_bits[it_code] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      due_mem[mem_waddr] <= mem_wdata;
    end
    mem_q  <= due_mem[scan_addr];
    map_q  <= map_bits[scan_addr];
    code_q <= scan_addr;
  end

  // scan: read, qualify, compare against best
  assign better = a_v && a_cand &&
                  (!best_found || a_tier < best_tier ||
                   (a_tier == best_tier && a_due < best_due));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= '0;
      rd_v       <= 1'b0;
      a_v        <= 1'b0;
      best_found <= 1'b0;
    end else begin
      rd_v <= cmd.scan_run;
      a_v  <= rd_v;
      if (cmd.scan_start) begin
        scan_addr  <= '0;
        best_found <= 1'b0;
      end else begin
        if (cmd.scan_run) begin
          scan_addr <= scan_addr + 8'd1;
        end
        if (better) begin
          best_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a_cand <= map_q && (mem_q <= it_now);
    a_tier <= tps_pkg::tier_of(code_q);
    a_code <= code_q;
    a_due  <= mem_q;
    if (better) begin
      best_tier <= a_tier;
      best_code <= a_code;
      best_due  <= a_due;
    end
    if (cmd.sched_calc) begin
      period_q <= tps_pkg::PERIOD_W'(interval) *
                  tps_pkg::PERIOD_W'(tps_pkg::period_mult(best_tier, congested));
    end
  end

  // diagnostic queue and outstanding flag
  always_ff @(posedge clk) begin
    if (cmd.enqueue && count != DEPTH_CNT) begin
      fifo_mem[tail] <= {it_mode, it_code};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      outstanding <= 1'b0;
    end else begin
      if (cmd.enqueue && count != DEPTH_CNT) begin
        tail  <= (tail == LAST_PTR) ? '0 : tail + PTR_W'(1);
        count <= count + CNT_W'(1);
      end
      if (cmd.dequeue) begin
        head  <= (head == LAST_PTR) ? '0 : head + PTR_W'(1);
        count <= count - CNT_W'(1);
      end
      if (cmd.dequeue || cmd.sched_write) begin
        outstanding <= 1'b1;
      end else if (cmd.complete) begin
        outstanding <= 1'b0;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_valid  <= 1'b0;
      res_mode   <= '0;
      res_code   <= '0;
      res_diag   <= 1'b0;
      res_status <= 1'b0;
    end else if (cmd.dequeue) begin
      res_valid <= 1'b1;
      res_mode  <= fifo_mem[head][15:8];
      res_code  <= fifo_mem[head][7:0];
      res_diag  <= 1'b1;
    end else if (cmd.sched_write) begin
      res_valid <= 1'b1;
      res_mode  <= tps_pkg::STREAM_MODE;
      res_code  <= best_code;
    end else if (cmd.enqueue && count == DEPTH_CNT) begin
      res_status <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {3'b000, res_status, interval, (count != '0), outstanding,
                  res_code, res_mode, res_valid};
      m_tuser <= res_diag;
    end
  end

  assign stat.op             = it_op;
  assign stat.outstanding    = outstanding;
  assign stat.queue_nonempty = (count != '0);
  assign stat.scan_last      = (scan_addr == 8'hFF);
  assign stat.pipe_busy      = rd_v || a_v;
  assign stat.found          = best_found;
  assign stat.out_free       = !m_tvalid || m_tready;

endmodule
`default_nettype wire

// ===== rtl/tiered_poll_scheduler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tiered_poll_scheduler_unit
// Keeps one link request outstanding: serves queued diagnostic requests first,
// else picks the best due streaming code by tier, due time and code.
// ----------------------------------------------------------------------------
// channel   dir  handshake             payload
// s_*       in   s_tvalid/s_tready     tuser op, tdata code/mode/now/rtt/timeout
// m_*       out  m_tvalid/m_tready     tuser from_diag, tdata request + status
// cfg_*     in   cfg_valid/cfg_ready   cfg_data congested_mode
//
// One beat at a time. Most ops pass through EXEC and EMIT before the output
// register loads; a map-scan poll adds SCAN, one due-time read per code over
// 256 codes, then FLUSH to drain, plus PERIOD and SCHED when a code is issued.
// Reset clears map, queue, outstanding flag, round-trip average, config.
// A finished result waits in the output register while the next beat runs;
// that beat stalls before its emit until the register drains.
// ----------------------------------------------------------------------------
module tiered_poll_scheduler_unit #(
  parameter int DIAG_QUEUE_DEPTH = 8,
  parameter int TIME_BITS        = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [7:0] param_code, [15:8] diag_mode, [63:16] now_ms, [79:64] round_trip_ms,
  // [80] timeout flag, [87:81] zero
  input  wire logic [tps_pkg::S_TDATA_W-1:0]  s_tdata,
  // [2:0] op
  input  wire logic [2:0]                     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [0] req_valid, [8:1] req_mode, [16:9] req_code, [17] busy_flag,
  // [18] streaming_paused, [35:19] dispatch_interval_ms, [36] status, [39:37] zero
  output logic [tps_pkg::M_TDATA_W-1:0]       m_tdata,
  // [0] req_from_diag
  output logic [0:0]                          m_tuser,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_data
);

  tps_pkg::cmd_t  cmd;
  tps_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  tps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tps_datapath #(
    .DIAG_QUEUE_DEPTH (DIAG_QUEUE_DEPTH),
    .TIME_BITS        (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

// ===== dv/tiered_poll_scheduler_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_poll_scheduler_unit_checker
// Watches the input, result and config channels of the poll scheduler. Keeps
// its own copy of the code map, due times, diagnostic queue, link state and
// round-trip average, predicts one result per accepted input beat, and
// compares every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tiered_poll_scheduler_unit_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [tps_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [2:0]                    s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [tps_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic [0:0]                    m_tuser,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_data,
  output int                            open_count,
  output int                            fail_count
);

  localparam int          DIAG_DEPTH = 8;
  localparam logic [47:0] TIME_MAX   = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic                      issued;
    logic [7:0]                mode;
    logic [7:0]                code;
    logic                      from_diag;
    logic                      busy;
    logic                      paused;
    logic [tps_pkg::IVL_W-1:0] interval;
    logic                      dropped;
  } poll_result_t;

  logic [tps_pkg::NUM_CODES-1:0] code_live = '0;
  logic [47:0]                   due_at[tps_pkg::NUM_CODES];
  logic [15:0]                   diag_q[$];
  logic                          link_busy = 1'b0;
  int unsigned                   rtt_avg = 0;
  logic                          congested = 1'b0;
  poll_result_t                  results_due[$];
  int                            errors = 0;

  function automatic tps_pkg::tier_t code_tier(input logic [7:0] c);
    case (c)
      8'h0C, 8'h0D, 8'h11:        return tps_pkg::TIER_HIGH;
      8'h04, 8'h0B, 8'h0E, 8'h10: return tps_pkg::TIER_MED;
      default: return (c >= 8'h14 && c <= 8'h2B) ? tps_pkg::TIER_MED : tps_pkg::TIER_LOW;
    endcase
  endfunction

  function automatic longint unsigned tier_mult(input tps_pkg::tier_t t);
    case (t)
      tps_pkg::TIER_HIGH: return 3;
      tps_pkg::TIER_MED:  return congested ? 10 : 6;
      default:            return congested ? 20 : 12;
    endcase
  endfunction

  function automatic logic [tps_pkg::IVL_W-1:0] dispatch_interval();
    int unsigned v;
    v = rtt_avg * 5 / 4;
    return (v < tps_pkg::INTERVAL_MIN) ? tps_pkg::INTERVAL_MIN : v[tps_pkg::IVL_W-1:0];
  endfunction

  function automatic poll_result_t schedule_step(input logic [2:0] op,
                                                 input logic [7:0] code,
                                                 input logic [7:0] mode,
                                                 input logic [47:0] now,
                                                 input logic [15:0] rtt,
                                                 input logic tmo);
    poll_result_t      r;
    int                best;
    tps_pkg::tier_t    bt;
    tps_pkg::tier_t    t;
    logic [15:0]       entry;
    longint unsigned   period;
    int unsigned       obs;
    r = '0;
    case (op)
      tps_pkg::OP_CLEAR: begin
        code_live = '0;
      end
      tps_pkg::OP_ADD: begin
        if (!code_live[code]) begin
          code_live[code] = 1'b1;
          due_at[code] = '0;
        end
      end
      tps_pkg::OP_ENQ: begin
        if (diag_q.size() >= DIAG_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          entry = {mode, code};
          diag_q.insert(diag_q.size(), entry);
        end
      end
      tps_pkg::OP_POLL: begin
        if (!link_busy) begin
          if (diag_q.size() != 0) begin
            entry = diag_q[0];
            diag_q.delete(0);
            link_busy = 1'b1;
            r.issued = 1'b1;
            r.mode = entry[15:8];
            r.code = entry[7:0];
            r.from_diag = 1'b1;
          end else begin
            best = -1;
            bt = tps_pkg::TIER_LOW;
            for (int c = 0; c < tps_pkg::NUM_CODES; c++) begin
              if (code_live[c] && due_at[c] <= now) begin
                t = code_tier(c[7:0]);
                if (best < 0 || t < bt || (t == bt && due_at[c] < due_at[best])) begin
                  best = c;
                  bt = t;
                end
              end
            end
            if (best >= 0) begin
              period = longint'(dispatch_interval()) * tier_mult(bt);
              due_at[best] = (period > 64'(TIME_MAX - now)) ? TIME_MAX : 48'(now + period);
              link_busy = 1'b1;
              r.issued = 1'b1;
              r.mode = tps_pkg::STREAM_MODE;
              r.code = best[7:0];
            end
          end
        end
      end
      tps_pkg::OP_COMPLETE: begin
        link_busy = 1'b0;
        obs = rtt;
        if (tmo && obs < tps_pkg::TIMEOUT_FLOOR) obs = tps_pkg::TIMEOUT_FLOOR;
        rtt_avg = (rtt_avg * 7 + obs) / 8;
      end
      default: ;
    endcase
    r.busy = link_busy;
    r.paused = (diag_q.size() != 0);
    r.interval = dispatch_interval();
    return r;
  endfunction

  task automatic compare_field(input string name, input longint unsigned exp_v,
                               input longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    poll_result_t got;
    poll_result_t want;
    poll_result_t pred;
    if (!rst) begin
      if (cfg_valid && cfg_ready) congested = cfg_data;
      if (s_tvalid && s_tready) begin
        pred = schedule_step(s_tuser, s_tdata[7:0], s_tdata[15:8],
                             s_tdata[63:16], s_tdata[79:64], s_tdata[80]);
        results_due.insert(results_due.size(), pred);
      end
      if (m_tvalid && m_tready) begin
        got.issued    = m_tdata[0];
        got.mode      = m_tdata[8:1];
        got.code      = m_tdata[16:9];
        got.from_diag = m_tuser[0];
        got.busy      = m_tdata[17];
        got.paused    = m_tdata[18];
        got.interval  = m_tdata[35:19];
        got.dropped   = m_tdata[36];
        if (results_due.size() == 0) begin
          $error("result beat with no pending request: %h", m_tdata);
          errors++;
        end else begin
          want = results_due[0];
          results_due.delete(0);
          compare_field("req_valid", want.issued, got.issued);
          compare_field("req_mode", want.mode, got.mode);
          compare_field("req_code", want.code, got.code);
          compare_field("req_from_diag", want.from_diag, got.from_diag);
          compare_field("busy_flag", want.busy, got.busy);
          compare_field("streaming_paused", want.paused, got.paused);
          compare_field("dispatch_interval_ms", want.interval, got.interval);
          compare_field("status", want.dropped, got.dropped);
        end
      end
    end
    open_count <= results_due.size();
    fail_count <= errors;
  end

endmodule

// ===== dv/tiered_poll_scheduler_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_poll_scheduler_unit_test
// Drives the poll scheduler with a directed pass over map, queue, poll and
// completion corner cases, then random poll/complete sessions mixed with code
// adds, queue bursts, map clears and noise, across alternating congestion
// settings. Sender and receiver both throttle; the checker does the scoring.
// ----------------------------------------------------------------------------
module tiered_poll_scheduler_unit_test;
  import tps_pkg::*;

  localparam int          QUIET_LIMIT   = 5000;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          HOLD_AFTER    = 150;
  localparam int          SETTLE_CYCLES = 300;
  localparam int          RANDOM_ITEMS  = 1000;
  localparam int          PHASES        = 6;
  localparam logic [2:0]  OP_RESERVED   = 3'd7;
  localparam logic [47:0] TIME_MAX      = 48'hFFFF_FFFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // [7:0] code, [15:8] mode, [63:16] now, [79:64] rtt, [80] tmo
  logic [2:0]           s_tuser;   // [2:0] op
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // [0] valid, [8:1] mode, [16:9] code, [17] busy, [18] paused,
                                   // [35:19] interval, [36] status
  logic [0:0]           m_tuser;   // [0] from_diag
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_data;
  int                   open_count;
  int                   fail_count;

  int                   burst_left;
  int                   sent_items;
  int                   live_codes;
  logic [47:0]          wall_ms;

  always #1 clk = ~clk;

  tiered_poll_scheduler_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tiered_poll_scheduler_unit_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .open_count (open_count),
    .fail_count (fail_count)
  );

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 11))
      0:       return 8'h0C;
      1:       return 8'h0D;
      2:       return 8'h11;
      3:       return 8'h04;
      4:       return 8'h0B;
      5:       return 8'h0E;
      6:       return 8'h10;
      7:       return 8'($urandom_range(8'h14, 8'h2B));
      8:       return 8'h2B;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_beat(input logic [2:0] op, input logic [7:0] code,
                           input logic [7:0] mode, input logic [47:0] now,
                           input logic [15:0] rtt, input logic tmo);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, tmo, rtt, now, mode, code};
    do @(posedge clk); while (!s_tready);
    sent_items++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_congested(input logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(input int items);
    int          stop_at;
    int          r;
    logic [15:0] rtt;
    logic        tmo;
    logic [63:0] wide;
    stop_at = sent_items + items;
    while (sent_items < stop_at) begin
      r = $urandom_range(0, 99);
      if (live_codes < 4 || r < 8) begin
        send_beat(OP_ADD, pick_code(), 8'($urandom), 48'($urandom), 16'($urandom), 1'($urandom));
        live_codes++;
      end else if (r < 12) begin
        repeat ($urandom_range(1, 10)) begin
          send_beat(OP_ENQ, 8'($urandom), 8'($urandom), '0, '0, 1'b0);
        end
      end else if (r < 14) begin
        send_beat(OP_CLEAR, '0, '0, '0, '0, 1'b0);
        live_codes = 0;
      end else if (r < 22) begin
        wide = {$urandom, $urandom};
        send_beat(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), wide[47:0],
                  16'($urandom), 1'($urandom));
      end else begin
        wall_ms = wall_ms + (($urandom_range(0, 19) == 0) ? $urandom_range(0, 2000000)
                                                           : $urandom_range(0, 400));
        send_beat(OP_POLL, 8'($urandom), 8'($urandom), wall_ms, 16'($urandom), 1'($urandom));
        if ($urandom_range(0, 9) != 0) begin
          case ($urandom_range(0, 9))
            0:       begin rtt = 16'($urandom);                 tmo = 1'b0; end
            1:       begin rtt = 16'($urandom_range(0, 999));   tmo = 1'b1; end
            2:       begin rtt = 16'($urandom_range(1000, 65535)); tmo = 1'b1; end
            default: begin rtt = 16'($urandom_range(1, 300));   tmo = 1'b0; end
          endcase
          send_beat(OP_COMPLETE, 8'($urandom), 8'($urandom), '0, rtt, tmo);
        end
      end
    end
  endtask

  // receiver: random ready pattern, one long hold-off once traffic is flowing
  initial begin : receiver
    int run_left;
    int stall_pct;
    int beats;
    int hold_left;
    bit held;
    m_tready <= 1'b0;
    run_left = 0;
    stall_pct = 0;
    beats = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) beats++;
      if (!held && beats >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (run_left == 0) begin
        run_left = $urandom_range(1, 60);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 95;
        endcase
      end
      run_left--;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    burst_left = 0;
    sent_items = 0;
    live_codes = 0;
    wall_ms    = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_congested(1'b0);

    // empty map and idle completion
    send_beat(OP_POLL, '0, '0, '0, '0, 1'b0);
    send_beat(OP_COMPLETE, '0, '0, '0, '0, 1'b0);
    // one code per tier plus extremes, then a duplicate add
    send_beat(OP_ADD, 8'h0C, '0, '0, '0, 1'b0);
    send_beat(OP_ADD, 8'h05, '0, '0, '0, 1'b0);
    send_beat(OP_ADD, 8'h14, '0, '0, '0, 1'b0);
    send_beat(OP_ADD, 8'h2B, '0, '0, '0, 1'b0);
    send_beat(OP_ADD, 8'hFF, '0, '0, '0, 1'b0);
    send_beat(OP_ADD, 8'h00, '0, '0, '0, 1'b0);
    send_beat(OP_ADD, 8'h0C, '0, '0, '0, 1'b0);
    send_beat(OP_POLL, '0, '0, '0, '0, 1'b0);
    send_beat(OP_POLL, '0, '0, '0, '0, 1'b0);
    send_beat(OP_COMPLETE, '0, '0, '0, 16'hFFFF, 1'b1);
    // due time saturates at the top of the time range
    send_beat(OP_POLL, 8'hFF, 8'hFF, TIME_MAX, 16'hFFFF, 1'b1);
    send_beat(OP_COMPLETE, '0, '0, '0, '0, 1'b1);
    send_beat(OP_RESERVED, 8'hFF, 8'hFF, TIME_MAX, 16'hFFFF, 1'b1);
    send_beat(OP_CLEAR, '0, '0, '0, '0, 1'b0);
    // fill the diagnostic queue and overflow it by one
    for (int i = 0; i < 9; i++) begin
      send_beat(OP_ENQ, i[0] ? 8'hFF : 8'(i), i[0] ? 8'h00 : ~8'(i), '0, '0, 1'b0);
    end
    send_beat(OP_POLL, '0, '0, '0, '0, 1'b0);
    send_beat(OP_COMPLETE, '0, '0, '0, 16'd100, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      wait_results_done();
      write_congested(~p[0]);
      run_traffic(RANDOM_ITEMS / PHASES);
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
